>>> rtl/dsrt_pkg.sv
// ----------------------------------------------------------------------------
// Density-sorted record table package
// Record layout, command codes and status codes shared by the table logic.
// ----------------------------------------------------------------------------
package dsrt_pkg;

  // Declared from the top bit down, so name_word0 sits in the lowest bits.
  typedef struct packed {
    logic [19:0] area;
    logic [30:0] population;
    logic [23:0] seat_word2;
    logic [63:0] seat_word1;
    logic [63:0] seat_word0;
    logic [23:0] code_word1;
    logic [63:0] code_word0;
    logic [63:0] name_word1;
    logic [63:0] name_word0;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef struct packed {
    logic denser;
    logic name_eq;
  } cmp_res_t;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_RANGE     = 3'd3;
  localparam logic [2:0] ST_ZERO_AREA = 3'd4;

endpackage

>>> rtl/dsrt_match.sv
// ----------------------------------------------------------------------------
// Density-sorted record table compare unit
// Cross-multiplies densities of a held record against a new record and
// matches names as zero-terminated strings; results appear in the cycle after their inputs.
// ----------------------------------------------------------------------------
module dsrt_match (
  input  logic            clk,
  input  dsrt_pkg::rec_t  held,
  input  dsrt_pkg::rec_t  key,
  output dsrt_pkg::cmp_res_t res
);
  import dsrt_pkg::*;

  logic [50:0] prod_key;
  logic [50:0] prod_held;
  logic        name_eq;
  logic        name_eq_comb;

  always_comb begin
    logic [127:0] ha;
    logic [127:0] kb;
    logic         done;
    ha = {held.name_word1, held.name_word0};
    kb = {key.name_word1, key.name_word0};
    done = 1'b0;
    name_eq_comb = 1'b1;
    for (int i = 0; i < 16; i++) begin
      if (!done) begin
        if (ha[i*8 +: 8] != kb[i*8 +: 8]) begin
          name_eq_comb = 1'b0;
          done = 1'b1;
        end else if (ha[i*8 +: 8] == 8'd0) begin
          done = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_key  <= key.population * held.area;
    prod_held <= held.population * key.area;
    name_eq   <= name_eq_comb;
  end

  assign res.denser  = prod_key > prod_held;
  assign res.name_eq = name_eq;

endmodule

>>> rtl/density_sorted_record_table.sv
// ----------------------------------------------------------------------------
// Density-sorted record table
// Keeps records in one memory, sorted by falling population density, with
// insert, delete-by-name and read-by-index commands.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  s_*     | in        | tuser: cmd; tdata: record fields and read_index
//  m_*     | out       | tdata: record fields, status, entry_count
//
// One command is worked at a time through the single record memory.
// An insert scans entries in SCAN_RD, SCAN_WAIT and SCAN_CHK, moves entries down
// in SH_RD and SH_WR and writes in WR_NEW; a delete moves entries up; a read uses RD_CAP.
// The scan rate is set by the memory read latency and the registered compare.
// Reset clears the entry count and the handshake state; memory is not cleared.
// A waiting result does not block the next transaction from being accepted.
module density_sorted_record_table #(
  parameter int CAPACITY = 64
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         s_tvalid,
  output logic                                         s_tready,
  // name_word0, name_word1, code_word0, code_word1, seat_word0, seat_word1,
  // seat_word2, population, area, read_index, zero fill
  input  logic [431:0]                                 s_tdata,
  // cmd
  input  logic [1:0]                                   s_tuser,
  output logic                                         m_tvalid,
  input  logic                                         m_tready,
  // out_name_word0, out_name_word1, out_code_word0, out_code_word1,
  // out_seat_word0, out_seat_word1, out_seat_word2, out_population,
  // out_area, status, entry_count, zero fill
  output logic [((422 + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] m_tdata
);
  import dsrt_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > 6) ? CW : 6;
  localparam int OW = ((422 + CW + 7) / 8) * 8;

  typedef enum logic [3:0] {
    IDLE, SCAN_RD, SCAN_WAIT, SCAN_CHK, SH_RD, SH_WR, WR_NEW,
    DL_RD, DL_WR, DL_END, RD_CAP, DONE
  } state_t;

  state_t         state;
  logic [1:0]     cmd_q;
  rec_t           rec_q;
  rec_t           out_rec;
  logic [2:0]     status_q;
  logic [CW-1:0]  count;
  logic [CW-1:0]  idx;
  logic [CW-1:0]  pos;

  rec_t           mem [CAPACITY];
  rec_t           rd_data;
  logic [IW-1:0]  mem_raddr;
  logic           mem_we;
  logic [IW-1:0]  mem_waddr;
  rec_t           mem_wdata;
  cmp_res_t       cmp;

  rec_t           in_rec;
  logic [5:0]     in_index;

  assign in_rec   = rec_t'(s_tdata[REC_W-1:0]);
  assign in_index = s_tdata[REC_W +: 6];
  assign s_tready = (state == IDLE);

  dsrt_match u_match (
    .clk  (clk),
    .held (rd_data),
    .key  (rec_q),
    .res  (cmp)
  );

  always_comb begin
    case (state)
      IDLE:    mem_raddr = IW'(in_index);
      SH_RD:   mem_raddr = IW'(idx - CW'(1));
      DL_RD:   mem_raddr = IW'(idx + CW'(1));
      default: mem_raddr = IW'(idx);
    endcase
    mem_we    = 1'b0;
    mem_waddr = IW'(idx);
    mem_wdata = rd_data;
    case (state)
      SH_WR, DL_WR: mem_we = 1'b1;
      WR_NEW: begin
        mem_we    = 1'b1;
        mem_waddr = IW'(pos);
        mem_wdata = rec_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // In DONE the result register is handled by that state alone.
      if (m_tvalid && m_tready && state != DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            cmd_q    <= s_tuser;
            rec_q    <= in_rec;
            out_rec  <= '0;
            status_q <= ST_OK;
            idx      <= '0;
            state    <= DONE;
            case (s_tuser)
              CMD_INSERT: begin
                if (in_rec.area == '0) begin
                  status_q <= ST_ZERO_AREA;
                end else if (count == CW'(CAPACITY)) begin
                  status_q <= ST_FULL;
                end else begin
                  state <= SCAN_RD;
                end
              end
              CMD_DELETE: state <= SCAN_RD;
              CMD_READ: begin
                if (XW'(in_index) >= XW'(count)) begin
                  status_q <= ST_RANGE;
                end else begin
                  state <= RD_CAP;
                end
              end
              default: ;
            endcase
          end
        end
        SCAN_RD: begin
          if (idx == count) begin
            if (cmd_q == CMD_INSERT) begin
              pos   <= count;
              idx   <= count;
              state <= WR_NEW;
            end else begin
              status_q <= ST_NOT_FOUND;
              state    <= DONE;
            end
          end else begin
            state <= SCAN_WAIT;
          end
        end
        SCAN_WAIT: state <= SCAN_CHK;
        SCAN_CHK: begin
          if (cmd_q == CMD_INSERT && cmp.denser) begin
            pos   <= idx;
            idx   <= count;
            state <= SH_RD;
          end else if (cmd_q != CMD_INSERT && cmp.name_eq) begin
            pos   <= idx;
            state <= (idx + CW'(1) == count) ? DL_END : DL_RD;
          end else begin
            idx   <= idx + CW'(1);
            state <= SCAN_RD;
          end
        end
        SH_RD: state <= SH_WR;
        SH_WR: begin
          idx   <= idx - CW'(1);
          state <= (idx - CW'(1) == pos) ? WR_NEW : SH_RD;
        end
        WR_NEW: begin
          count <= count + CW'(1);
          state <= DONE;
        end
        DL_RD: state <= DL_WR;
        DL_WR: begin
          idx   <= idx + CW'(1);
          state <= (idx + CW'(2) == count) ? DL_END : DL_RD;
        end
        DL_END: begin
          count <= count - CW'(1);
          state <= DONE;
        end
        RD_CAP: begin
          out_rec <= rd_data;
          state   <= DONE;
        end
        DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OW'({count, status_q, out_rec});
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == SCAN_WAIT) |-> (idx < count))
    else $error("scan read beyond held entries");

  a_done_emits: assert property (@(posedge clk) disable iff (rst)
    (state == DONE && (!m_tvalid || m_tready)) |=> (m_tvalid && state == IDLE))
    else $error("finished command did not produce a result");

  a_count_changes: assert property (@(posedge clk) disable iff (rst)
    !$stable(count) |-> ($past(state) == WR_NEW || $past(state) == DL_END))
    else $error("entry count changed outside insert or delete");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Density-sorted record table testbench
// Sends insert, delete, read and unused-code transactions with random gaps and stalls on
// both sides, predicts each result with an in-order record table of its own,
// and compares every returned transaction field by field.
// ----------------------------------------------------------------------------
module testbench;
  import dsrt_pkg::*;

  localparam int CAP       = 64;
  localparam int OUT_W     = ((422 + $clog2(CAP + 1) + 7) / 8) * 8;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic [6:0]   entry_count;
    logic [2:0]   status;
    rec_t         rec;
  } answer_t;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [431:0]     s_tdata;
  logic [1:0]       s_tuser;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;

  density_sorted_record_table #(.CAPACITY(CAP)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Predicted table contents, index 0 is the densest record.
  rec_t    sorted_recs[$];
  answer_t expected_answers[$];
  int      mismatch_count;
  int      answers_seen;
  int      sent_count;
  int      stall_hold;
  int      hold_requests;
  int      hold_served;
  bit      stall_on;
  int      name_pool_size;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic bit names_equal(rec_t a, rec_t b);
    logic [127:0] x;
    logic [127:0] y;
    x = {a.name_word1, a.name_word0};
    y = {b.name_word1, b.name_word0};
    for (int i = 0; i < 16; i++) begin
      if (x[i*8 +: 8] != y[i*8 +: 8]) return 1'b0;
      if (x[i*8 +: 8] == 8'd0) return 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic answer_t predict_table(logic [1:0] cmd, rec_t r, logic [5:0] idx);
    answer_t a;
    logic [50:0] lhs;
    logic [50:0] rhs;
    int pos;
    a = '0;
    if (cmd == CMD_INSERT) begin
      if (r.area == 0) a.status = ST_ZERO_AREA;
      else if (sorted_recs.size() >= CAP) a.status = ST_FULL;
      else begin
        pos = sorted_recs.size();
        for (int i = 0; i < sorted_recs.size(); i++) begin
          lhs = 51'(r.population) * 51'(sorted_recs[i].area);
          rhs = 51'(sorted_recs[i].population) * 51'(r.area);
          if (lhs > rhs) begin
            pos = i;
            break;
          end
        end
        sorted_recs.insert(pos, r);
        a.status = ST_OK;
      end
    end else if (cmd == CMD_DELETE) begin
      a.status = ST_NOT_FOUND;
      for (int i = 0; i < sorted_recs.size(); i++) begin
        if (names_equal(sorted_recs[i], r)) begin
          sorted_recs.delete(i);
          a.status = ST_OK;
          break;
        end
      end
    end else if (cmd == CMD_READ) begin
      if (idx >= sorted_recs.size()) a.status = ST_RANGE;
      else a.rec = sorted_recs[idx];
    end
    a.entry_count = 7'(sorted_recs.size());
    return a;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Names come from a small pool so that deletes often hit.
  function automatic rec_t random_record();
    rec_t r;
    r.name_word0 = ($urandom_range(0, 9) == 0) ? rand64() :
                   64'h4e00 | 64'($urandom_range(0, name_pool_size - 1));
    r.name_word1 = ($urandom_range(0, 7) == 0) ? rand64() : 64'd0;
    r.code_word0 = rand64();
    r.code_word1 = 24'($urandom());
    r.seat_word0 = rand64();
    r.seat_word1 = rand64();
    r.seat_word2 = 24'($urandom());
    case ($urandom_range(0, 5))
      0: r.population = 31'($urandom_range(0, 3));
      1: r.population = 31'h7fffffff;
      default: r.population = 31'($urandom());
    endcase
    case ($urandom_range(0, 9))
      0: r.area = 20'd0;
      1: r.area = 20'hfffff;
      2: r.area = 20'($urandom_range(1, 4));
      default: r.area = 20'($urandom());
    endcase
    return r;
  endfunction

  task automatic send_command(logic [1:0] cmd, rec_t r, logic [5:0] idx);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 :
          ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    repeat (gap) @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = cmd;
    s_tdata  = {7'd0, idx, r};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_answers.push_back(predict_table(cmd, r, idx));
    sent_count++;
    @(negedge clk);
    s_tvalid = 1'b0;
    s_tdata  = 432'(rand64());
  endtask

  task automatic drain_answers();
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed();
    rec_t r;
    r = '0;
    send_command(CMD_DELETE, r, 6'd0);
    send_command(CMD_READ, r, 6'd0);
    r.name_word0 = 64'h41;
    r.population = 31'd10;
    r.area = 20'd0;
    send_command(CMD_INSERT, r, 6'd0);
    r.area = 20'd5;
    send_command(CMD_INSERT, r, 6'd0);
    r.name_word0 = 64'h42;
    r.population = 31'd4;
    r.area = 20'd2;
    send_command(CMD_INSERT, r, 6'd0);
    r = '1;
    r.name_word0 = 64'h43;
    r.name_word1 = '1;
    send_command(CMD_INSERT, r, 6'd0);
    r = '0;
    r.name_word0 = 64'h44;
    r.area = 20'hfffff;
    send_command(CMD_INSERT, r, 6'd0);
    for (int i = 0; i < 5; i++) send_command(CMD_READ, r, 6'(i));
    send_command(CMD_READ, r, 6'd63);
    send_command(CMD_UNUSED, '1, 6'd63);
    r.name_word0 = 64'hff41;
    send_command(CMD_DELETE, r, 6'd0);
    r.name_word0 = 64'h41;
    send_command(CMD_DELETE, r, 6'd0);
    r.name_word0 = 64'h43;
    r.name_word1 = '1;
    send_command(CMD_DELETE, r, 6'd0);
    send_command(CMD_READ, r, 6'd1);
    drain_answers();
  endtask

  // Fill to capacity with ties and inserts into the full table, with the receiver held off.
  task automatic test_full_table();
    rec_t r;
    hold_requests++;
    for (int i = 0; i < CAP + 3; i++) begin
      r = random_record();
      r.area = (i % 3 == 0) ? 20'd7 : r.area | 20'd1;
      if (i % 3 == 0) r.population = 31'd70;
      send_command(CMD_INSERT, r, 6'd0);
    end
    send_command(CMD_READ, r, 6'd63);
    drain_answers();
  endtask

  task automatic test_random(int count);
    rec_t r;
    int pick;
    for (int i = 0; i < count; i++) begin
      r = random_record();
      pick = $urandom_range(0, 99);
      if (pick < 45) send_command(CMD_INSERT, r, 6'd0);
      else if (pick < 75) send_command(CMD_DELETE, r, 6'($urandom()));
      else if (pick < 97) send_command(CMD_READ, r,
          ($urandom_range(0, 4) == 0) ? 6'($urandom()) :
          6'($urandom_range(0, sorted_recs.size() + 1)));
      else send_command(CMD_UNUSED, r, 6'($urandom()));
    end
    drain_answers();
  endtask

  // Receiver side: random readiness plus forced long holds.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_hold <= 0;
      hold_served <= 0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      stall_hold <= LONG_HOLD;
      m_tready <= 1'b0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
      m_tready <= 1'b0;
    end else if (stall_on) begin
      m_tready <= ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 199) == 0) stall_hold <= $urandom_range(10, 60);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[$bits(answer_t)-1:0];
      answers_seen++;
      if (expected_answers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result transaction %h", got);
      end else begin
        want = expected_answers.pop_front();
        if (got.rec != want.rec || got.status != want.status ||
            got.entry_count != want.entry_count || m_tdata[OUT_W-1:$bits(answer_t)] != 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: status %0d/%0d count %0d/%0d\n exp rec %h\n got rec %h",
                     want.status, got.status, want.entry_count, got.entry_count,
                     want.rec, got.rec);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    hold_requests = 0;
    stall_on = 1'b0;
    mismatch_count = 0;
    answers_seen = 0;
    sent_count = 0;
    name_pool_size = 24;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    stall_on = 1'b1;
    test_full_table();
    test_random(450);
    name_pool_size = 200;
    test_random(400);
    $display("Sent %0d commands and checked %0d results, including a full table,",
             sent_count, answers_seen);
    $display("zero area, missing names, out of range reads and receiver stalls.");
    if (mismatch_count == 0 && expected_answers.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> density_sorted_record_table.f
rtl/dsrt_pkg.sv
rtl/dsrt_match.sv
rtl/density_sorted_record_table.sv
tb/sv/testbench.sv
